// File: rtl/core/adc_channel_scan_spi_reader_top_assert.svh
// Assertion macros for the converter scan reader
`ifndef ADC_CHANNEL_SCAN_SPI_READER_TOP_ASSERT_SVH
`define ADC_CHANNEL_SCAN_SPI_READER_TOP_ASSERT_SVH

// Check a property on the rising clock, skipped while reset is held
`define ACSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock, also during reset
`define ACSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/acsr_pkg.sv
`timescale 1ns / 1ps

package acsr_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W = 12;
  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned LINES_W = 3;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned POS_W   = 5;

  // Serial frame layout
  localparam int unsigned CMD_BITS    = 5;
  localparam int unsigned IDLE_CLOCKS = 2;
  localparam logic [1:0]  CMD_PREFIX  = 2'b11;  // start bit, single-ended bit
  localparam logic [SEL_W-1:0] LINE_MAX = 2'd2;

  // Parameter defaults
  localparam int unsigned DEF_CHANNEL_COUNT = 8;
  localparam int unsigned DEF_SAMPLE_BITS   = 12;

  // Request codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // One result item
  typedef struct packed {
    logic               chip_select_n;
    logic               serial_clock;
    logic               serial_data_out;
    logic               sample_valid;
    logic [CHAN_W-1:0]  sample_channel;
    logic [VALUE_W-1:0] sample_value;
    logic               scan_last;
    logic               busy_flag;
  } res_t;

endpackage

// File: rtl/core/adc_channel_scan_spi_reader_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload
// in_       request    command, converter_select, dout_lines
// out_      result     chip_select_n, serial_clock, serial_data_out, sample_valid,
//                      sample_channel, sample_value, scan_last, busy_flag
//
// One request is one half-clock tick of the serial bus; every request gives one result.
// Throughput is one request per cycle while in_stall is low: the scan counters and the
// receive shift register update in the cycle a request is accepted.
// Reset (rst_n low, synchronous) returns the scanner to idle and empties the output.
// A two-entry output (result register plus skid register) keeps accepting while a
// result is stalled; in_stall rises only once both entries are full.
module adc_channel_scan_spi_reader_top
  import acsr_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = DEF_CHANNEL_COUNT,
  parameter int unsigned SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [SEL_W-1:0]   in_converter_select,
  input  logic [LINES_W-1:0] in_dout_lines,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_chip_select_n,
  output logic               out_serial_clock,
  output logic               out_serial_data_out,
  output logic               out_sample_valid,
  output logic [CHAN_W-1:0]  out_sample_channel,
  output logic [VALUE_W-1:0] out_sample_value,
  output logic               out_scan_last,
  output logic               out_busy_flag
);

  localparam logic [POS_W-1:0] DATA_FIRST = POS_W'(1 + CMD_BITS + IDLE_CLOCKS);
  localparam logic [POS_W-1:0] FINAL_POS  = POS_W'(CMD_BITS + IDLE_CLOCKS + SAMPLE_BITS);
  localparam logic [POS_W-1:0] CMD_LAST   = POS_W'(CMD_BITS);
  localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNEL_COUNT - 1);

  // Scan state
  logic               scan_active_r, scan_active_nxt;
  logic [CHAN_W-1:0]  channel_r, channel_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               phase_high_r, phase_high_nxt;
  logic [VALUE_W-1:0] rx_bits_r, rx_bits_nxt;
  logic [SEL_W-1:0]   line_r, line_nxt;

  // Output buffer
  logic out_valid_r, skid_valid_r;
  res_t out_data_r, skid_data_r;
  res_t res;

  logic in_acc, out_take;
  logic [CMD_BITS-1:0] cmd_word;
  logic [POS_W-1:0]    cmd_pos;
  logic [2:0]          cmd_idx;
  logic                data_bit;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid & ~skid_valid_r;
  assign out_take = out_valid_r & ~out_stall;

  // Pick the command bit for the current clock, holding channel bit 0 after it
  assign cmd_word = {CMD_PREFIX, channel_r};
  assign cmd_pos  = (pos_r > CMD_LAST) ? CMD_LAST : pos_r;
  assign cmd_idx  = 3'(CMD_LAST - cmd_pos);
  assign data_bit = in_dout_lines[line_r];

  // Advance the scan by one half tick
  always_comb begin
    scan_active_nxt = scan_active_r;
    channel_nxt     = channel_r;
    pos_nxt         = pos_r;
    phase_high_nxt  = phase_high_r;
    rx_bits_nxt     = rx_bits_r;
    line_nxt        = line_r;
    res             = '0;
    res.chip_select_n = 1'b1;

    if (!scan_active_r) begin
      if (in_command == CMD_START) begin
        scan_active_nxt = 1'b1;
        line_nxt        = (in_converter_select >= LINE_MAX) ? LINE_MAX : in_converter_select;
        channel_nxt     = '0;
        pos_nxt         = '0;
        phase_high_nxt  = 1'b0;
        rx_bits_nxt     = '0;
        res.busy_flag   = 1'b1;
      end
    end else begin
      res.busy_flag = 1'b1;
      if (pos_r == '0) begin
        // Deselect tick
        rx_bits_nxt    = '0;
        pos_nxt        = POS_W'(1);
        phase_high_nxt = 1'b0;
      end else begin
        res.chip_select_n   = 1'b0;
        res.serial_data_out = cmd_word[cmd_idx];
        if (!phase_high_r) begin
          phase_high_nxt = 1'b1;
        end else begin
          res.serial_clock = 1'b1;
          phase_high_nxt   = 1'b0;
          if (pos_r >= DATA_FIRST) begin
            rx_bits_nxt = {rx_bits_r[VALUE_W-2:0], data_bit};
          end
          if (pos_r >= FINAL_POS) begin
            res.sample_valid   = 1'b1;
            res.sample_channel = channel_r;
            res.sample_value   = rx_bits_nxt;
            pos_nxt            = '0;
            if (channel_r == LAST_CHAN) begin
              res.scan_last   = 1'b1;
              scan_active_nxt = 1'b0;
              channel_nxt     = '0;
            end else begin
              channel_nxt = channel_r + CHAN_W'(1);
            end
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
    end
  end

  // Hold scan state, update on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_active_r <= 1'b0;
      channel_r     <= '0;
      pos_r         <= '0;
      phase_high_r  <= 1'b0;
      rx_bits_r     <= '0;
      line_r        <= '0;
    end else if (in_acc) begin
      scan_active_r <= scan_active_nxt;
      channel_r     <= channel_nxt;
      pos_r         <= pos_nxt;
      phase_high_r  <= phase_high_nxt;
      rx_bits_r     <= rx_bits_nxt;
      line_r        <= line_nxt;
    end
  end

  // Track output and skid occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      out_valid_r  <= skid_valid_r | in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Move result payloads
  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (in_acc) begin
      skid_data_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_chip_select_n   = out_data_r.chip_select_n;
  assign out_serial_clock    = out_data_r.serial_clock;
  assign out_serial_data_out = out_data_r.serial_data_out;
  assign out_sample_valid    = out_data_r.sample_valid;
  assign out_sample_channel  = out_data_r.sample_channel;
  assign out_sample_value    = out_data_r.sample_value;
  assign out_scan_last       = out_data_r.scan_last;
  assign out_busy_flag       = out_data_r.busy_flag;

  `include "adc_channel_scan_spi_reader_top_assert.svh"

  `ACSR_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid full while result register empty")
  `ACSR_ASSERT(a_sample_on_rise, (out_valid_r && out_data_r.sample_valid) |-> (!out_data_r.chip_select_n && out_data_r.serial_clock && out_data_r.busy_flag), "sample outside a selected rising tick")
  `ACSR_ASSERT(a_last_channel, (out_valid_r && out_data_r.scan_last) |-> (out_data_r.sample_valid && out_data_r.sample_channel == LAST_CHAN), "scan end without final channel sample")
  `ACSR_ASSERT(a_idle_after_last, (in_acc && res.scan_last) |=> !scan_active_r, "scanner still active after final sample")

endmodule
